>>> hdl/bfdc_pkg.sv
// bfdc_pkg: shared types and constants of the byte FIFO with delimiter count.
// Used by every module of the block except bfdc_ram; depends on nothing.
`default_nettype none

package bfdc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned POS_W   = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_NODELIM = 2'd3
  } status_e;

  typedef struct packed {
    mode_e             mode;
    logic [BYTE_W-1:0] push_byte;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [BYTE_W-1:0]  data_byte;
    logic [POS_W-1:0]   byte_position;
    logic               last;
    logic [COUNT_W-1:0] delimiters_held;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;       // write byte at head, register ok result
    logic    imm;        // register a one-shot result with imm_status
    status_e imm_status;
    logic    start_pop;  // clear line position
    logic    emit;       // take tail byte, register its result
    logic    line;       // current pop is a line pop
    logic    cfg_we;     // write delimiter register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic count_zero;
    logic stop;          // byte now being taken ends the pop
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/bfdc_ram.sv
// bfdc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/bfdc_ctrl.sv
// bfdc_ctrl: controller state machine, decodes commands and sequences pops.
// Depends on bfdc_pkg.
`default_nettype none

module bfdc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire bfdc_pkg::mode_e     mode_i,
  input  wire logic                cfg_valid_i,
  input  wire bfdc_pkg::dp_status_t dp_status_i,
  output bfdc_pkg::ctrl_cmd_t      ctrl_cmd_o,
  output logic                     busy_o
);
  import bfdc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   line_q, line_d;

  always_comb begin
    state_d    = state_q;
    line_d     = line_q;
    ctrl_cmd_o = '0;
    ctrl_cmd_o.imm_status = STAT_OK;
    ctrl_cmd_o.line       = line_q;
    // never on the edge that takes a command
    ctrl_cmd_o.cfg_we     = cfg_valid_i && (state_q == S_IDLE) && !start_i;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (mode_i)
            MODE_PUSH: begin
              if (dp_status_i.full) begin
                ctrl_cmd_o.imm        = 1'b1;
                ctrl_cmd_o.imm_status = STAT_FULL;
              end else begin
                ctrl_cmd_o.push = 1'b1;
              end
            end
            MODE_POP: begin
              if (dp_status_i.empty) begin
                ctrl_cmd_o.imm        = 1'b1;
                ctrl_cmd_o.imm_status = STAT_EMPTY;
              end else begin
                ctrl_cmd_o.start_pop = 1'b1;
                line_d  = 1'b0;
                state_d = S_EMIT;
              end
            end
            MODE_LINE: begin
              if (dp_status_i.count_zero) begin
                ctrl_cmd_o.imm        = 1'b1;
                ctrl_cmd_o.imm_status = STAT_NODELIM;
              end else if (dp_status_i.empty) begin
                ctrl_cmd_o.imm        = 1'b1;
                ctrl_cmd_o.imm_status = STAT_EMPTY;
              end else begin
                ctrl_cmd_o.start_pop = 1'b1;
                line_d  = 1'b1;
                state_d = S_EMIT;
              end
            end
            default: begin
              // unused mode: plain ok result
              ctrl_cmd_o.imm = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        ctrl_cmd_o.emit = 1'b1;
        if (dp_status_i.stop) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      line_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/bfdc_dpath.sv
// bfdc_dpath: pointers, delimiter count and register, byte store, result register.
// Depends on bfdc_pkg and bfdc_ram.
`default_nettype none

module bfdc_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [bfdc_pkg::BYTE_W-1:0] push_byte_i,
  input  wire logic [bfdc_pkg::BYTE_W-1:0] cfg_data_i,
  input  wire bfdc_pkg::ctrl_cmd_t        ctrl_cmd_i,
  output bfdc_pkg::dp_status_t            dp_status_o,
  output logic                            result_valid_o,
  output bfdc_pkg::result_t               result_o
);
  import bfdc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0]   head_nxt, tail_nxt, rd_addr;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0]  delim_q;
  logic [BYTE_W-1:0]  rdata;
  logic               valid_q;
  result_t            res_q, res_d;
  logic               stop;

  assign head_nxt = ptr_next(head_q);
  assign tail_nxt = ptr_next(tail_q);
  // keep the read one step ahead while bytes stream out
  assign rd_addr  = ctrl_cmd_i.emit ? tail_nxt : tail_q;

  bfdc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_cmd_i.push),
    .waddr_i(head_q),
    .wdata_i(push_byte_i),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign stop = !ctrl_cmd_i.line || (rdata == delim_q) || (tail_nxt == head_q);

  assign dp_status_o.empty      = (head_q == tail_q);
  assign dp_status_o.full       = (head_nxt == tail_q);
  assign dp_status_o.count_zero = (count_q == '0);
  assign dp_status_o.stop       = stop;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    pos_d   = pos_q;
    res_d   = res_q;
    if (ctrl_cmd_i.push) begin
      head_d = head_nxt;
      if (push_byte_i == delim_q && count_q != COUNT_MAX) begin
        count_d = count_q + 1'b1;
      end
    end
    if (ctrl_cmd_i.start_pop) begin
      pos_d = '0;
    end
    if (ctrl_cmd_i.emit) begin
      tail_d = tail_nxt;
      pos_d  = pos_q + 1'b1;
      if (rdata == delim_q && count_q != '0) begin
        count_d = count_q - 1'b1;
      end
    end
    if (ctrl_cmd_i.push || ctrl_cmd_i.imm) begin
      res_d.status          = ctrl_cmd_i.push ? STAT_OK : ctrl_cmd_i.imm_status;
      res_d.data_byte       = '0;
      res_d.byte_position   = '0;
      res_d.last            = 1'b1;
      res_d.delimiters_held = count_d;
    end else if (ctrl_cmd_i.emit) begin
      res_d.status          = STAT_OK;
      res_d.data_byte       = rdata;
      res_d.byte_position   = ctrl_cmd_i.line ? pos_q + 1'b1 : '0;
      res_d.last            = stop;
      res_d.delimiters_held = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      delim_q <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      valid_q <= ctrl_cmd_i.push || ctrl_cmd_i.imm || ctrl_cmd_i.emit;
      if (ctrl_cmd_i.cfg_we) begin
        delim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

>>> hdl/byte_fifo_with_delimiter_count.sv
// byte_fifo_with_delimiter_count: top level, joins controller and datapath.
// Depends on bfdc_pkg, bfdc_ctrl, bfdc_dpath (and through it bfdc_ram).
//
//   channel   handshake                      payload
//   --------  -----------------------------  --------------------------------
//   command   start_i, busy_o (start&!busy)  cmd_i    : bfdc_pkg::cmd_t
//   result    result_valid_o, one cycle      result_o : bfdc_pkg::result_t
//   config    cfg_valid_i, cfg_ready_o       cfg_data_i : delimiter byte
//
// Timing: push, failed pops and the unused mode show their result the cycle
// after the transaction; the next command can follow at once. A pop of N bytes
// (N = 1 for a single pop) holds busy_o while it runs; its results come one per
// cycle, through the registered read of the byte store and the result register.
// Reset: asynchronous, active low; the byte store itself is not cleared.
// Stalls: none from the receiver; config is taken only idle and with no start.
`default_nettype none

module byte_fifo_with_delimiter_count #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command transaction
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire bfdc_pkg::cmd_t              cmd_i,
  // result strobe
  output logic                             result_valid_o,
  output bfdc_pkg::result_t                result_o,
  // delimiter register write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bfdc_pkg::BYTE_W-1:0] cfg_data_i
);
  import bfdc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // controller: decides per command what the datapath does
  bfdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .mode_i     (cmd_i.mode),
    .cfg_valid_i(cfg_valid_i),
    .dp_status_i(dp_status),
    .ctrl_cmd_o (ctrl_cmd),
    .busy_o     (busy_o)
  );

  // datapath: store, pointers, count, registered result
  bfdc_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_byte_i   (cmd_i.push_byte),
    .cfg_data_i    (cfg_data_i),
    .ctrl_cmd_i    (ctrl_cmd),
    .dp_status_o   (dp_status),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // register writes only between transactions, never beside a new command
  assign cfg_ready_o = !busy_o && !start_i;

endmodule

`default_nettype wire

>>> hdl/bfdc_checker.sv
// bfdc_checker: port-level assertions for the byte FIFO, bound to the top level.
// Depends on bfdc_pkg and byte_fifo_with_delimiter_count.
`default_nettype none

module bfdc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              result_valid_o,
  input wire bfdc_pkg::result_t result_o,
  input wire logic              cfg_ready_o
);
  import bfdc_pkg::*;

  // a pop streams its bytes without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("gap inside a multi-byte pop");

  // every accepted command gives a result or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> result_valid_o || busy_o)
    else $error("accepted transaction produced nothing");

  // failures are always single, final results with no payload
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != STAT_OK |->
      result_o.last && result_o.data_byte == '0 && result_o.byte_position == '0)
    else $error("failure result not final or carries data");

  // a non-final result only comes from a line pop, so it has a position
  a_line_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> result_o.byte_position != '0)
    else $error("non-final result without line position");

  // config is blocked while a pop runs
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o)
    else $error("config ready while busy");

endmodule

bind byte_fifo_with_delimiter_count bfdc_checker u_bfdc_checker (.*);

`default_nettype wire

>>> tb/sv/bfdc_result_checker.sv
// bfdc_result_checker: watches the command, result and delimiter channels of
// byte_fifo_with_delimiter_count, predicts every result and compares it.
// Depends on bfdc_pkg only.
`timescale 1ns / 100ps

module bfdc_result_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_i,
  input  wire bfdc_pkg::cmd_t              cmd_i,
  input  wire logic                        result_valid_i,
  input  wire bfdc_pkg::result_t           result_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [bfdc_pkg::BYTE_W-1:0] cfg_data_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      outstanding_o
);
  import bfdc_pkg::*;

  localparam int unsigned MAX_PRINTED = 60;

  // shadow copy of the FIFO
  logic [BYTE_W-1:0]  fifo_mem [DEPTH];
  int unsigned        wr_ptr = 0;
  int unsigned        rd_ptr = 0;
  logic [COUNT_W-1:0] delim_cnt = '0;
  logic [BYTE_W-1:0]  delim_reg = '0;

  result_t            response_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        outstanding = 0;

  assign mismatch_count_o = mismatch_count;
  assign outstanding_o    = outstanding;

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
  endtask

  // result fields are taken with the count as it stands after the update
  task automatic queue_response(input status_e st, input logic [BYTE_W-1:0] data,
                                input logic [POS_W-1:0] pos, input logic last);
    result_t r;
    r.status          = st;
    r.data_byte       = data;
    r.byte_position   = pos;
    r.last            = last;
    r.delimiters_held = delim_cnt;
    response_q.push_back(r);
  endtask

  task automatic take_oldest(output logic [BYTE_W-1:0] b);
    b      = fifo_mem[rd_ptr];
    rd_ptr = next_slot(rd_ptr);
    if (b == delim_reg && delim_cnt != '0) delim_cnt--;
  endtask

  task automatic fifo_respond(input cmd_t c);
    logic [BYTE_W-1:0] b;
    int unsigned       n;
    logic              stop;
    case (c.mode)
      MODE_PUSH: begin
        if (next_slot(wr_ptr) == rd_ptr) begin
          queue_response(STAT_FULL, '0, '0, 1'b1);
        end else begin
          fifo_mem[wr_ptr] = c.push_byte;
          wr_ptr           = next_slot(wr_ptr);
          if (c.push_byte == delim_reg && delim_cnt != COUNT_MAX) delim_cnt++;
          queue_response(STAT_OK, '0, '0, 1'b1);
        end
      end
      MODE_POP: begin
        if (rd_ptr == wr_ptr) begin
          queue_response(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          take_oldest(b);
          queue_response(STAT_OK, b, '0, 1'b1);
        end
      end
      MODE_LINE: begin
        if (delim_cnt == '0) begin
          queue_response(STAT_NODELIM, '0, '0, 1'b1);
        end else if (rd_ptr == wr_ptr) begin
          queue_response(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          n    = 0;
          stop = 1'b0;
          // ends on the delimiter, or runs dry when the count is stale
          while (!stop && rd_ptr != wr_ptr && n < COUNT_MAX) begin
            take_oldest(b);
            n++;
            stop = (b == delim_reg) || (rd_ptr == wr_ptr);
            queue_response(STAT_OK, b, POS_W'(n), stop);
          end
        end
      end
      default: begin
        queue_response(STAT_OK, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (response_q.size() == 0) begin
      report_mismatch($sformatf("result with none outstanding: %p", got));
    end else begin
      want = response_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %h, predicted %h",
                                  got.data_byte, want.data_byte));
      if (got.byte_position !== want.byte_position)
        report_mismatch($sformatf("byte_position %0d, predicted %0d",
                                  got.byte_position, want.byte_position));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
      if (got.delimiters_held !== want.delimiters_held)
        report_mismatch($sformatf("delimiters_held %0d, predicted %0d",
                                  got.delimiters_held, want.delimiters_held));
    end
  endtask

  // results at an edge belong to earlier transactions, so compare first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr    = 0;
      rd_ptr    = 0;
      delim_cnt = '0;
      delim_reg = '0;
      response_q.delete();
    end else begin
      if (result_valid_i) check_result(result_i);
      if (start_i && !busy_i) fifo_respond(cmd_i);
      if (cfg_valid_i && cfg_ready_i) delim_reg = cfg_data_i;
    end
    outstanding = response_q.size();
  end

endmodule

>>> tb/sv/tb_byte_fifo_with_delimiter_count.sv
// tb_byte_fifo_with_delimiter_count: stimulus and verdict for the byte FIFO
// with delimiter count. Depends on bfdc_pkg, the block and bfdc_result_checker.
`timescale 1ns / 100ps

module tb_byte_fifo_with_delimiter_count;
  import bfdc_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned ITEMS_PER_LEG  = 85;  // random commands per delimiter setting
  localparam int unsigned NUM_LEGS       = 6;
  localparam int unsigned TAIL_CYCLES    = 20;  // catches stray results after drain

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  cmd_t              cmd       = '0;
  logic              cfg_valid = 1'b0;
  logic [BYTE_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              res_valid;
  result_t           res;
  logic              cfg_ready;

  int unsigned       mismatch_count;
  int unsigned       outstanding;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent  = 0;
  int unsigned       no_gap_left = 0;   // remaining commands of a back-to-back run
  logic [BYTE_W-1:0] delim_now   = '0;  // what the block holds as delimiter

  byte_fifo_with_delimiter_count #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .cmd_i         (cmd),
    .result_valid_o(res_valid),
    .result_o      (res),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  bfdc_result_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd),
    .result_valid_i  (res_valid),
    .result_i        (res),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs or drops results
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("byte_fifo_with_delimiter_count test failed");
      $finish;
    end
  end

  // Any byte except the current delimiter, so lines end where intended.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if (b == delim_now) b = b ^ 8'h01;
    return b;
  endfunction

  // One command transaction. Called at a rising edge. The idle gap is drawn
  // at random per command, except inside a back-to-back run. With no gap, start
  // simply stays high, so it is never lowered and raised in one time step.
  task automatic send_item(input mode_e m, input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (no_gap_left != 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd.mode      <= m;
    cmd.push_byte <= b;
    // transaction completes at the first edge that sees busy low
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Sender pauses until every outstanding result has come back.
  // Sampled on the falling edge so the checker's update at the rising edge
  // has settled; returns on a rising edge.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Delimiter writes only happen with the block idle.
  task automatic write_delimiter(input logic [BYTE_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    delim_now  = value;
  endtask

  initial begin
    logic [BYTE_W-1:0] leg_delims [NUM_LEGS];
    int unsigned       leg_end;
    int unsigned       pick;

    leg_delims = '{8'hFF, 8'h0A, 8'h00, 8'h80, 8'h00, 8'h00};
    leg_delims[2] = BYTE_W'($urandom);
    leg_delims[5] = BYTE_W'($urandom);

    // reset held low from the start, released once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    // delimiter is 0 after reset
    send_item(MODE_POP, 8'h00);        // pop on empty FIFO
    send_item(MODE_LINE, 8'hFF);       // line pop with zero count
    send_item(MODE_UNUSED, 8'hA5);     // unused mode, ignored
    send_item(MODE_PUSH, 8'h55);       // not a delimiter yet, count stays 0

    // count saturates at zero: stored byte becomes the delimiter afterwards
    write_delimiter(8'h55);
    send_item(MODE_POP, 8'h00);        // removes 0x55, count must stay 0

    write_delimiter(8'h00);
    send_item(MODE_PUSH, 8'h00);       // delimiter, count 1
    send_item(MODE_PUSH, 8'hFF);
    send_item(MODE_PUSH, 8'h00);       // count 2
    send_item(MODE_LINE, 8'h00);       // one-byte line
    send_item(MODE_LINE, 8'h00);       // two-byte line, count back to 0
    send_item(MODE_LINE, 8'h00);       // nothing left to find
    send_item(MODE_POP, 8'hFF);        // empty again

    // line pop that runs dry: count is stale after the delimiter changes
    write_delimiter(8'h41);
    send_item(MODE_PUSH, 8'h41);
    send_item(MODE_PUSH, 8'h41);       // count 2
    write_delimiter(8'h42);
    send_item(MODE_PUSH, 8'h10);
    send_item(MODE_LINE, 8'h00);       // drains all three, last on empty
    send_item(MODE_LINE, 8'h00);       // count nonzero but FIFO empty
    send_item(MODE_PUSH, 8'h42);       // count 3
    send_item(MODE_POP, 8'h00);        // count 2

    // ---------------- random part ----------------
    // Each leg runs under its own delimiter; the FIFO content carries over
    // between legs so stale counts and saturation get exercised.
    for (int leg = 0; leg < NUM_LEGS; leg++) begin
      write_delimiter(leg_delims[leg]);
      leg_end = items_sent + ITEMS_PER_LEG;
      while (items_sent < leg_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // well-formed line: plain bytes then the delimiter
          repeat ($urandom_range(0, 10)) send_item(MODE_PUSH, plain_byte());
          send_item(MODE_PUSH, delim_now);
        end else if (pick < 60) begin
          repeat ($urandom_range(1, 2)) send_item(MODE_LINE, BYTE_W'($urandom));
        end else if (pick < 75) begin
          // noise: any mode, any byte
          send_item(mode_e'($urandom_range(0, 3)), BYTE_W'($urandom));
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 6)) send_item(MODE_POP, BYTE_W'($urandom));
        end else if (pick < 89) begin
          wait_drained();
        end else if (pick < 95) begin
          // broken line: random bytes, maybe no delimiter at all
          repeat ($urandom_range(1, 8)) send_item(MODE_PUSH, BYTE_W'($urandom));
        end else if (pick < 98) begin
          // longest line: fill to the brim, try one more, pop it all as one line
          repeat (DEPTH - 2) send_item(MODE_PUSH, plain_byte());
          send_item(MODE_PUSH, delim_now);
          send_item(MODE_PUSH, delim_now);
          send_item(MODE_LINE, 8'h00);
        end else begin
          // delimiters only: drives the count toward its ceiling
          repeat (DEPTH) send_item(MODE_PUSH, delim_now);
        end
      end
    end

    // ---------------- end of run ----------------
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("byte_fifo_with_delimiter_count test passed");
    end else begin
      $display("byte_fifo_with_delimiter_count test failed");
    end
    $finish;
  end

endmodule
